>>> rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// Each macro expects a clk and rst signal in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BPR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bpr_pkg.sv
// Shared types and constants for the byte pipe.
// No dependencies.
package bpr_pkg;

  localparam int PIPE_DEPTH        = 512;
  localparam int MAX_ENDPOINT_REFS = 255;

  localparam int PTR_W  = $clog2(PIPE_DEPTH);
  localparam int FILL_W = $clog2(PIPE_DEPTH + 1);
  localparam int REF_W  = $clog2(MAX_ENDPOINT_REFS + 1);

  localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(PIPE_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(PIPE_DEPTH);
  localparam logic [REF_W-1:0]  REF_MAX   = REF_W'(MAX_ENDPOINT_REFS);

  typedef enum logic [2:0] {
    OP_CREATE    = 3'd0,
    OP_READ      = 3'd1,
    OP_WRITE     = 3'd2,
    OP_RETAIN_RD = 3'd3,
    OP_RETAIN_WR = 3'd4,
    OP_CLOSE_RD  = 3'd5,
    OP_CLOSE_WR  = 3'd6,
    OP_NONE      = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_EOS    = 3'd2,
    ST_FULL   = 3'd3,
    ST_BROKEN = 3'd4
  } status_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic take;   // input beat accepted this cycle
  } cmd_t;

endpackage

>>> rtl/bpr_ctrl.sv
// Handshake controller for the byte pipe: tracks whether a result beat is held.
// Depends on bpr_pkg.
module bpr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output bpr_pkg::cmd_t cmd
);
  import bpr_pkg::*;

  typedef enum logic {
    S_EMPTY,
    S_HOLD
  } state_t;

  state_t state;
  logic   take;

  // Accept a new beat whenever the result slot is free or drains this cycle.
  assign in_stall  = (state == S_HOLD) && out_stall;
  assign take      = in_valid && !in_stall;
  assign out_valid = (state == S_HOLD);
  assign cmd.take  = take;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_EMPTY;
    end else begin
      case (state)
        S_EMPTY: begin
          if (take) state <= S_HOLD;
        end
        S_HOLD: begin
          if (!out_stall && !take) state <= S_EMPTY;
        end
        default: state <= S_EMPTY;
      endcase
    end
  end

endmodule

>>> rtl/bpr_datapath.sv
// Byte pipe datapath: ring buffer memory, pointers, fill and endpoint counts,
// and the result register. Depends on bpr_pkg.
module bpr_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  bpr_pkg::cmd_t             cmd,
  input  logic [2:0]                operation,
  input  logic [7:0]                write_byte,
  input  logic                      burst_last,
  output logic [7:0]                read_byte,
  output logic [2:0]                status,
  output logic [bpr_pkg::FILL_W-1:0] fill_level,
  output logic                      released,
  output logic                      last_echo
);
  import bpr_pkg::*;

  logic [7:0]        mem [PIPE_DEPTH];
  logic [7:0]        mem_q;

  logic [PTR_W-1:0]  read_pointer, read_pointer_next;
  logic [PTR_W-1:0]  write_pointer, write_pointer_next;
  logic [FILL_W-1:0] byte_count, byte_count_next;
  logic [REF_W-1:0]  reader_count, reader_count_next;
  logic [REF_W-1:0]  writer_count, writer_count_next;

  status_t           stat_next;
  status_t           stat_q;
  logic              rd_ok, rd_ok_q;
  logic              wr_en;
  logic              live;
  logic              fill_q_rel;
  logic [FILL_W-1:0] fill_q;
  logic              last_q;

  assign live = (reader_count != '0) || (writer_count != '0);

  always_comb begin
    read_pointer_next  = read_pointer;
    write_pointer_next = write_pointer;
    byte_count_next    = byte_count;
    reader_count_next  = reader_count;
    writer_count_next  = writer_count;
    stat_next          = ST_OK;
    rd_ok              = 1'b0;
    wr_en              = 1'b0;
    case (op_t'(operation))
      OP_CREATE: begin
        read_pointer_next  = '0;
        write_pointer_next = '0;
        byte_count_next    = '0;
        reader_count_next  = REF_W'(1);
        writer_count_next  = REF_W'(1);
      end
      OP_READ: begin
        if (byte_count != '0) begin
          rd_ok             = 1'b1;
          read_pointer_next = (read_pointer == PTR_LAST) ? '0 : read_pointer + PTR_W'(1);
          byte_count_next   = byte_count - FILL_W'(1);
        end else begin
          stat_next = (writer_count == '0) ? ST_EOS : ST_EMPTY;
        end
      end
      OP_WRITE: begin
        if (reader_count == '0) begin
          stat_next = ST_BROKEN;
        end else if (byte_count >= FILL_FULL) begin
          stat_next = ST_FULL;
        end else begin
          wr_en              = 1'b1;
          write_pointer_next = (write_pointer == PTR_LAST) ? '0 : write_pointer + PTR_W'(1);
          byte_count_next    = byte_count + FILL_W'(1);
        end
      end
      OP_RETAIN_RD: begin
        if (live && reader_count < REF_MAX) reader_count_next = reader_count + REF_W'(1);
      end
      OP_RETAIN_WR: begin
        if (live && writer_count < REF_MAX) writer_count_next = writer_count + REF_W'(1);
      end
      OP_CLOSE_RD, OP_CLOSE_WR: begin
        if (operation == OP_CLOSE_RD) begin
          if (reader_count != '0) reader_count_next = reader_count - REF_W'(1);
        end else begin
          if (writer_count != '0) writer_count_next = writer_count - REF_W'(1);
        end
        // Release: drop all buffered bytes.
        if (reader_count_next == '0 && writer_count_next == '0) begin
          read_pointer_next  = '0;
          write_pointer_next = '0;
          byte_count_next    = '0;
        end
      end
      default: ;
    endcase
  end

  // Buffer memory with registered read at the current read pointer.
  always_ff @(posedge clk) begin
    if (cmd.take && wr_en) mem[write_pointer] <= write_byte;
    if (cmd.take) mem_q <= mem[read_pointer];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_pointer  <= '0;
      write_pointer <= '0;
      byte_count    <= '0;
      reader_count  <= REF_W'(1);
      writer_count  <= REF_W'(1);
    end else if (cmd.take) begin
      read_pointer  <= read_pointer_next;
      write_pointer <= write_pointer_next;
      byte_count    <= byte_count_next;
      reader_count  <= reader_count_next;
      writer_count  <= writer_count_next;
    end
  end

  // Result register: hold until the next accepted beat.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      stat_q     <= stat_next;
      rd_ok_q    <= rd_ok;
      fill_q     <= byte_count_next;
      fill_q_rel <= (reader_count_next == '0) && (writer_count_next == '0);
      last_q     <= burst_last;
    end
  end

  assign read_byte  = rd_ok_q ? mem_q : 8'd0;
  assign status     = stat_q;
  assign fill_level = fill_q;
  assign released   = fill_q_rel;
  assign last_echo  = last_q;

endmodule

>>> rtl/byte_pipe_with_endpoint_refs.sv
// Byte pipe top level: joins the handshake controller and the datapath.
// Depends on bpr_pkg, bpr_ctrl and bpr_datapath.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one operation per beat:
//   create, read, write, retain or close of a reader or writer endpoint,
//   with write_byte for writes and burst_last echoed back unchanged.
//   Output channel (out_valid/out_stall) returns exactly one result beat
//   per input beat, in order: read_byte, status, fill_level, released and
//   last_echo.
// Timing:
//   A result appears in the cycle after its input beat is accepted. The block
//   takes one beat per cycle unless a result is stalled; the single result
//   register sets that rate; a new beat is taken as the held result drains.
//   The buffer memory is read through a registered port at the read pointer
//   on every accepted beat, so a write followed directly by a read sees it.
// Stall: while out_stall holds a result, in_stall is raised and nothing moves.
// Reset: pointers and fill count clear, both endpoint counts become one, and
//   no result is pending. Buffer contents are not cleared.
module byte_pipe_with_endpoint_refs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 operation,
  input  logic [7:0]                 write_byte,
  input  logic                       burst_last,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 read_byte,
  output logic [2:0]                 status,
  output logic [bpr_pkg::FILL_W-1:0] fill_level,
  output logic                       released,
  output logic                       last_echo
);
  import bpr_pkg::*;

  cmd_t cmd;

  bpr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  bpr_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .operation  (operation),
    .write_byte (write_byte),
    .burst_last (burst_last),
    .read_byte  (read_byte),
    .status     (status),
    .fill_level (fill_level),
    .released   (released),
    .last_echo  (last_echo)
  );

endmodule

>>> rtl/bpr_checker.sv
// Port-level checks for the byte pipe, bound to the top level.
// Depends on bpr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bpr_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic [7:0]                 read_byte,
  input logic [2:0]                 status,
  input logic [bpr_pkg::FILL_W-1:0] fill_level,
  input logic                       released
);
  import bpr_pkg::*;

  `BPR_ASSERT_NEXT(a_result_follows, in_valid && !in_stall, out_valid,
                   "no result after accepted beat")
  `BPR_ASSERT_NOW(a_byte_only_on_ok, out_valid && status != ST_OK, read_byte == 8'd0,
                  "read_byte set on failed op")
  `BPR_ASSERT_NOW(a_released_empty, out_valid && released, fill_level == '0,
                  "released pipe holds bytes")
  `BPR_ASSERT_NOW(a_fill_bound, out_valid, fill_level <= FILL_FULL,
                  "fill level above depth")
  `BPR_ASSERT_NOW(a_full_level, out_valid && status == ST_FULL, fill_level == FILL_FULL,
                  "full status below depth")

endmodule

bind byte_pipe_with_endpoint_refs bpr_checker u_bpr_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .read_byte  (read_byte),
  .status     (status),
  .fill_level (fill_level),
  .released   (released)
);

>>> dv/tb_byte_pipe_with_endpoint_refs.sv
// Self-checking testbench for the byte pipe with endpoint reference counts.
// Drives operation beats from a queue, predicts each result in-line and
// compares every result beat field by field. Depends on bpr_pkg and the RTL.
module tb_byte_pipe_with_endpoint_refs;
  timeunit 1ns;
  timeprecision 1ps;

  import bpr_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_BEATS = 1950;

  typedef struct {
    op_t         op;
    logic [7:0]  wbyte;
    logic        last;
    int unsigned gap;
    bit          drain;
  } pipe_op_t;

  typedef struct packed {
    logic [7:0]        read_byte;
    status_t           status;
    logic [FILL_W-1:0] fill_level;
    logic              released;
    logic              last_echo;
  } pipe_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [2:0]        operation = 3'd0;
  logic [7:0]        write_byte = 8'd0;
  logic              burst_last = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        read_byte;
  logic [2:0]        status;
  logic [FILL_W-1:0] fill_level;
  logic              released;
  logic              last_echo;

  pipe_op_t     op_queue[$];
  pipe_result_t expected_results[$];
  pipe_op_t     cur_op;
  pipe_result_t want;

  int  cycle_count    = 0;
  int  mismatch_count = 0;
  int  gap_left       = 0;
  int  stall_left     = 0;
  int  calm_left      = 0;
  bit  zero_gaps      = 1'b0;
  bit  beat_taken     = 1'b0;
  bit  result_taken   = 1'b0;

  // Predicted pipe state
  logic [7:0]        pipe_store [PIPE_DEPTH];
  logic [PTR_W-1:0]  pipe_rd_ptr  = '0;
  logic [PTR_W-1:0]  pipe_wr_ptr  = '0;
  logic [FILL_W-1:0] pipe_fill    = '0;
  logic [REF_W-1:0]  pipe_readers = REF_W'(1);
  logic [REF_W-1:0]  pipe_writers = REF_W'(1);

  byte_pipe_with_endpoint_refs dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .write_byte (write_byte),
    .burst_last (burst_last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_byte  (read_byte),
    .status     (status),
    .fill_level (fill_level),
    .released   (released),
    .last_echo  (last_echo)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(string msg);
    if (mismatch_count < 50) $display("MISMATCH @%0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  function automatic void push_beat(op_t op, logic [7:0] wbyte, logic last, bit drain);
    pipe_op_t p;
    p.op    = op;
    p.wbyte = wbyte;
    p.last  = last;
    p.gap   = zero_gaps ? 0 : $urandom_range(0, 14);
    p.drain = drain;
    op_queue.push_back(p);
  endfunction

  function automatic void clear_pipe();
    pipe_rd_ptr = '0;
    pipe_wr_ptr = '0;
    pipe_fill   = '0;
  endfunction

  function automatic pipe_result_t predict_pipe_result(op_t op, logic [7:0] wbyte, logic last);
    pipe_result_t r;
    logic live;
    r.read_byte = 8'd0;
    r.status    = ST_OK;
    r.last_echo = last;
    live = (pipe_readers != 0) || (pipe_writers != 0);
    case (op)
      OP_CREATE: begin
        clear_pipe();
        pipe_readers = REF_W'(1);
        pipe_writers = REF_W'(1);
      end
      OP_READ: begin
        if (pipe_fill != 0) begin
          r.read_byte = pipe_store[pipe_rd_ptr];
          pipe_rd_ptr = (pipe_rd_ptr == PTR_LAST) ? '0 : pipe_rd_ptr + 1'b1;
          pipe_fill   = pipe_fill - 1'b1;
        end else begin
          r.status = (pipe_writers == 0) ? ST_EOS : ST_EMPTY;
        end
      end
      OP_WRITE: begin
        if (pipe_readers == 0) begin
          r.status = ST_BROKEN;
        end else if (pipe_fill >= FILL_FULL) begin
          r.status = ST_FULL;
        end else begin
          pipe_store[pipe_wr_ptr] = wbyte;
          pipe_wr_ptr = (pipe_wr_ptr == PTR_LAST) ? '0 : pipe_wr_ptr + 1'b1;
          pipe_fill   = pipe_fill + 1'b1;
        end
      end
      OP_RETAIN_RD: if (live && pipe_readers < REF_MAX) pipe_readers = pipe_readers + 1'b1;
      OP_RETAIN_WR: if (live && pipe_writers < REF_MAX) pipe_writers = pipe_writers + 1'b1;
      OP_CLOSE_RD, OP_CLOSE_WR: begin
        if (op == OP_CLOSE_RD && pipe_readers != 0) pipe_readers = pipe_readers - 1'b1;
        if (op == OP_CLOSE_WR && pipe_writers != 0) pipe_writers = pipe_writers - 1'b1;
        if (pipe_readers == 0 && pipe_writers == 0) clear_pipe();
      end
      default: ;
    endcase
    r.fill_level = pipe_fill;
    r.released   = (pipe_readers == 0) && (pipe_writers == 0);
    return r;
  endfunction

  // Driver: present beats at the falling edge, hold until taken.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !beat_taken) begin
      // hold the stalled beat
    end else if (gap_left != 0) begin
      in_valid <= 1'b0;
      gap_left = gap_left - 1;
    end else if (op_queue.size() != 0 &&
                 !(op_queue[0].drain && expected_results.size() != 0)) begin
      cur_op = op_queue.pop_front();
      operation  <= cur_op.op;
      write_byte <= cur_op.wbyte;
      burst_last <= cur_op.last;
      in_valid   <= 1'b1;
      gap_left = (op_queue.size() != 0) ? op_queue[0].gap : 0;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: draw a stall run per result beat, with calm stretches.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (result_taken) begin
        if (calm_left != 0) begin
          calm_left--;
          stall_left = 0;
        end else if ($urandom_range(0, 19) == 0) begin
          calm_left  = $urandom_range(10, 60);
          stall_left = 0;
        end else begin
          stall_left = $urandom_range(0, 14);
        end
      end
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Monitor: check result beats first, then record the newly taken beat.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      beat_taken   = !rst && in_valid && !in_stall;
      result_taken = !rst && out_valid && !out_stall;
      if (result_taken) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with no expectation waiting");
        end else begin
          want = expected_results.pop_front();
          if (read_byte !== want.read_byte)
            report_mismatch($sformatf("read_byte %0h want %0h", read_byte, want.read_byte));
          if (status !== want.status)
            report_mismatch($sformatf("status %0d want %0d", status, want.status));
          if (fill_level !== want.fill_level)
            report_mismatch($sformatf("fill_level %0d want %0d", fill_level, want.fill_level));
          if (released !== want.released)
            report_mismatch($sformatf("released %0b want %0b", released, want.released));
          if (last_echo !== want.last_echo)
            report_mismatch($sformatf("last_echo %0b want %0b", last_echo, want.last_echo));
        end
      end
      if (beat_taken)
        expected_results.push_back(predict_pipe_result(op_t'(operation), write_byte, burst_last));
    end
  end

  initial begin
    int  kind;
    int  len;
    bit  saturated;
    saturated = 1'b0;

    // Directed: empty reads, byte extremes, endpoint edge cases, release.
    push_beat(OP_READ,      8'h00, 1'b0, 1'b0);
    push_beat(OP_WRITE,     8'h00, 1'b0, 1'b0);
    push_beat(OP_WRITE,     8'hFF, 1'b1, 1'b0);
    push_beat(OP_READ,      8'h00, 1'b1, 1'b0);
    push_beat(OP_READ,      8'hFF, 1'b0, 1'b0);
    push_beat(OP_READ,      8'h00, 1'b0, 1'b0);
    push_beat(OP_NONE,      8'hFF, 1'b1, 1'b0);
    push_beat(OP_RETAIN_RD, 8'h00, 1'b0, 1'b0);
    push_beat(OP_RETAIN_WR, 8'h00, 1'b1, 1'b0);
    push_beat(OP_CLOSE_RD,  8'h00, 1'b0, 1'b0);
    push_beat(OP_CLOSE_RD,  8'h00, 1'b0, 1'b0);
    push_beat(OP_WRITE,     8'h3C, 1'b1, 1'b0);
    push_beat(OP_READ,      8'h00, 1'b0, 1'b0);
    push_beat(OP_CLOSE_WR,  8'h00, 1'b0, 1'b0);
    push_beat(OP_CLOSE_WR,  8'h00, 1'b1, 1'b0);
    push_beat(OP_RETAIN_RD, 8'h00, 1'b0, 1'b0);
    push_beat(OP_RETAIN_WR, 8'h00, 1'b0, 1'b0);
    push_beat(OP_READ,      8'h00, 1'b1, 1'b0);
    push_beat(OP_WRITE,     8'hC3, 1'b0, 1'b0);
    push_beat(OP_CLOSE_WR,  8'h00, 1'b0, 1'b0);
    push_beat(OP_CREATE,    8'h00, 1'b1, 1'b0);
    push_beat(OP_WRITE,     8'h81, 1'b0, 1'b0);
    push_beat(OP_CLOSE_WR,  8'h00, 1'b0, 1'b0);
    push_beat(OP_READ,      8'h00, 1'b1, 1'b0);
    push_beat(OP_READ,      8'h00, 1'b0, 1'b0);

    // Fill past full after a full drain of outstanding results.
    push_beat(OP_CREATE, 8'h00, 1'b0, 1'b1);
    repeat (PIPE_DEPTH + 18) push_beat(OP_WRITE, 8'($urandom), 1'($urandom), 1'b0);

    while (op_queue.size() < RANDOM_BEATS) begin
      zero_gaps = ($urandom_range(0, 9) < 3);
      if (!saturated && op_queue.size() > 1000) begin
        // Drive both endpoint counts into saturation.
        saturated = 1'b1;
        push_beat(OP_CREATE, 8'($urandom), 1'($urandom), 1'b0);
        repeat (MAX_ENDPOINT_REFS + 3) push_beat(OP_RETAIN_RD, 8'($urandom), 1'($urandom), 1'b0);
        repeat (MAX_ENDPOINT_REFS + 3) push_beat(OP_RETAIN_WR, 8'($urandom), 1'($urandom), 1'b0);
      end
      kind = $urandom_range(0, 99);
      len  = $urandom_range(1, 48);
      if (kind < 35) begin
        repeat (len)
          push_beat(($urandom_range(0, 7) == 0) ? OP_READ : OP_WRITE,
                    8'($urandom), 1'($urandom), ($urandom_range(0, 199) == 0));
      end else if (kind < 65) begin
        repeat (len)
          push_beat(($urandom_range(0, 7) == 0) ? OP_WRITE : OP_READ,
                    8'($urandom), 1'($urandom), ($urandom_range(0, 199) == 0));
      end else if (kind < 80) begin
        repeat ($urandom_range(1, 8))
          push_beat(op_t'($urandom_range(OP_RETAIN_RD, OP_CLOSE_WR)),
                    8'($urandom), 1'($urandom), 1'b0);
      end else if (kind < 86) begin
        push_beat(OP_CREATE, 8'($urandom), 1'($urandom), ($urandom_range(0, 3) == 0));
      end else begin
        repeat ($urandom_range(1, 10))
          push_beat(op_t'($urandom_range(0, 7)), 8'($urandom), 1'($urandom), 1'b0);
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (op_queue.size() != 0 || in_valid) @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    // Allow time for any stray result beat to appear.
    repeat (8) @(negedge clk);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
